>>> hw/rtl/gdv_pkg.sv
`default_nettype none
package gdv_pkg;

    localparam int unsigned MaxVertices = 64;
    localparam int unsigned AdjSlots    = MaxVertices + 1;
    localparam int unsigned VidW        = 6;
    localparam int unsigned LenW        = 7;
    localparam int unsigned AdjDepth    = MaxVertices * AdjSlots;
    localparam int unsigned AdjAddrW    = 13;
    localparam int unsigned StackW      = VidW + LenW;

    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_EDGE   = 2'd1,
        OP_WALK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_VISIT   = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_SELF,
        S_EDGE_B,
        S_WALK_LEN,
        S_WALK_CHK,
        S_WALK_ADJ,
        S_WALK_POP
    } state_t;

    // One row of the vertex table: adjacency length and edge bitmap.
    typedef struct packed {
        logic [LenW-1:0]        len;
        logic [MaxVertices-1:0] bits;
    } row_t;

endpackage
`default_nettype wire

>>> hw/rtl/gdv_ram.sv
`default_nettype none
module gdv_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/gdv_vertex_table.sv
`default_nettype none
module gdv_vertex_table
    import gdv_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire logic [VidW-1:0] wr_addr,
    input  wire row_t            wr_data,
    input  wire logic [VidW-1:0] rd_addr,
    output row_t                 rd_data
);

    row_t                   mem [MaxVertices];
    row_t                   rd_raw_reg;
    logic                   rd_valid_reg;
    logic [MaxVertices-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    // Rows never written read as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule
`default_nettype wire

>>> hw/rtl/graph_dfs_visit_order_core.sv
`default_nettype none
// Undirected graph engine with depth-first walk.
//
// Input channel: an item (op, vertex_a, vertex_b) is taken at a rising edge
// with start high and busy low. Insert vertex finishes at once and leaves
// busy low. A missing-vertex error from an edge or walk comes out in the cycle
// after the beat, also without raising busy.
// Insert edge: read-modify-write of the vertex table row of each endpoint
// plus one adjacency append per endpoint; busy in S_EDGE_A alone on a
// duplicate edge, which gives one result beat, and S_EDGE_A then S_EDGE_B
// (S_EDGE_SELF for a self-loop) on a new edge. Walk: length fetch and
// end-of-list check for the start vertex, issue read and check visited per
// adjacency entry, and per further vertex visited its length fetch and
// end-of-list check, the stack read and the parent's length fetch. Busy
// stays high for the whole walk and drops as the final beat comes out.
// Result channel: result_strobe marks each result beat for one cycle; the
// receiver must take it. One visit is held back so the final beat of a walk
// carries last.
// Reset clears present and visited marks, the vertex table row valid bits and
// the controller; memories holding adjacency lists and the stack need none.
module graph_dfs_visit_order_core
    import gdv_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      op,
    input  wire logic [VidW-1:0] vertex_a,
    input  wire logic [VidW-1:0] vertex_b,
    output logic                 result_strobe,
    output logic [1:0]           status,
    output logic [VidW-1:0]      vertex_id,
    output logic                 last
);

    state_t state_reg, state_next;

    logic [MaxVertices-1:0] present_reg, present_next;
    logic [MaxVertices-1:0] visited_reg, visited_next;

    logic [VidW-1:0] a_reg, a_next;
    logic [VidW-1:0] b_reg, b_next;
    logic [LenW-1:0] len_a_reg, len_a_next;
    logic [VidW-1:0] cur_u_reg, cur_u_next;
    logic [LenW-1:0] cur_i_reg, cur_i_next;
    logic [LenW-1:0] cur_len_reg, cur_len_next;
    logic [VidW-1:0] depth_reg, depth_next;
    logic [VidW-1:0] pend_reg, pend_next;

    logic            strobe_reg, strobe_next;
    logic [1:0]      status_reg, status_next;
    logic [VidW-1:0] vid_reg, vid_next;
    logic            last_reg, last_next;

    // vertex table
    logic            vt_wr_en;
    logic [VidW-1:0] vt_wr_addr, vt_rd_addr;
    row_t            vt_wr_data, vt_rd_data;

    // adjacency memory
    logic                adj_wr_en;
    logic [AdjAddrW-1:0] adj_wr_addr, adj_rd_addr;
    logic [VidW-1:0]     adj_wr_data, adj_rd_data;

    // stack memory: saved (vertex, resume index) below the cached top
    logic              stk_wr_en;
    logic [VidW-1:0]   stk_wr_addr, stk_rd_addr;
    logic [StackW-1:0] stk_wr_data, stk_rd_data;

    logic [MaxVertices-1:0] b_hot, a_hot;

    gdv_vertex_table u_vt (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (vt_wr_en),
        .wr_addr (vt_wr_addr),
        .wr_data (vt_wr_data),
        .rd_addr (vt_rd_addr),
        .rd_data (vt_rd_data)
    );

    gdv_ram #(
        .WIDTH  (VidW),
        .DEPTH  (AdjDepth),
        .ADDR_W (AdjAddrW)
    ) u_adj (
        .clk     (clk),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    gdv_ram #(
        .WIDTH  (StackW),
        .DEPTH  (MaxVertices),
        .ADDR_W (VidW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // Flat adjacency address: vertex * AdjSlots + index.
    function automatic logic [AdjAddrW-1:0] adj_addr(input logic [VidW-1:0] v,
                                                     input logic [LenW-1:0] i);
        adj_addr = AdjAddrW'({v, 6'b0}) + AdjAddrW'(v) + AdjAddrW'(i);
    endfunction

    assign b_hot = MaxVertices'(1) << b_reg;
    assign a_hot = MaxVertices'(1) << a_reg;

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        visited_next = visited_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        len_a_next   = len_a_reg;
        cur_u_next   = cur_u_reg;
        cur_i_next   = cur_i_reg;
        cur_len_next = cur_len_reg;
        depth_next   = depth_reg;
        pend_next    = pend_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        vid_next     = vid_reg;
        last_next    = last_reg;

        vt_wr_en    = 1'b0;
        vt_wr_addr  = a_reg;
        vt_wr_data  = vt_rd_data;
        vt_rd_addr  = vertex_a;
        adj_wr_en   = 1'b0;
        adj_wr_addr = adj_addr(a_reg, len_a_reg);
        adj_wr_data = b_reg;
        adj_rd_addr = adj_addr(cur_u_reg, cur_i_reg);
        stk_wr_en   = 1'b0;
        stk_wr_addr = depth_reg;
        stk_wr_data = {cur_u_reg, cur_i_reg};
        stk_rd_addr = depth_reg - VidW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next = vertex_a;
                    b_next = vertex_b;
                    unique case (op_t'(op))
                        OP_VERTEX:
                        begin
                            present_next[vertex_a] = 1'b1;
                        end
                        OP_EDGE:
                        begin
                            if (!present_reg[vertex_a] || !present_reg[vertex_b])
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_MISSING;
                                vid_next    = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EDGE_A;
                            end
                        end
                        OP_WALK:
                        begin
                            if (!present_reg[vertex_a])
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_MISSING;
                                vid_next    = '0;
                                last_next   = 1'b1;
                            end
                            else if (!visited_reg[vertex_a])
                            begin
                                visited_next[vertex_a] = 1'b1;
                                pend_next  = vertex_a;
                                cur_u_next = vertex_a;
                                cur_i_next = '0;
                                depth_next = '0;
                                state_next = S_WALK_LEN;
                            end
                        end
                        OP_NONE:
                        begin
                        end
                    endcase
                end
            end

            S_EDGE_A:
            begin
                // row a is on the read port
                if (vt_rd_data.bits[b_reg])
                begin
                    strobe_next = 1'b1;
                    status_next = ST_DUP;
                    vid_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    vt_wr_en        = 1'b1;
                    vt_wr_addr      = a_reg;
                    vt_wr_data.bits = vt_rd_data.bits | b_hot;
                    vt_wr_data.len  = vt_rd_data.len +
                                      ((a_reg == b_reg) ? LenW'(2) : LenW'(1));
                    adj_wr_en   = 1'b1;
                    adj_wr_addr = adj_addr(a_reg, vt_rd_data.len);
                    adj_wr_data = b_reg;
                    len_a_next  = vt_rd_data.len;
                    vt_rd_addr  = b_reg;
                    state_next  = (a_reg == b_reg) ? S_EDGE_SELF : S_EDGE_B;
                end
            end

            S_EDGE_SELF:
            begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = adj_addr(a_reg, len_a_reg + LenW'(1));
                adj_wr_data = a_reg;
                state_next  = S_IDLE;
            end

            S_EDGE_B:
            begin
                vt_wr_en        = 1'b1;
                vt_wr_addr      = b_reg;
                vt_wr_data.bits = vt_rd_data.bits | a_hot;
                vt_wr_data.len  = vt_rd_data.len + LenW'(1);
                adj_wr_en   = 1'b1;
                adj_wr_addr = adj_addr(b_reg, vt_rd_data.len);
                adj_wr_data = a_reg;
                state_next  = S_IDLE;
            end

            S_WALK_LEN:
            begin
                cur_len_next = vt_rd_data.len;
                state_next   = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                if (cur_i_reg < cur_len_reg)
                begin
                    // issue the adjacency read, advance the index
                    cur_i_next = cur_i_reg + LenW'(1);
                    state_next = S_WALK_ADJ;
                end
                else if (depth_reg == '0)
                begin
                    // walk done: drop the held visit with last set
                    strobe_next = 1'b1;
                    status_next = ST_VISIT;
                    vid_next    = pend_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    depth_next = depth_reg - VidW'(1);
                    state_next = S_WALK_POP;
                end
            end

            S_WALK_ADJ:
            begin
                if (!visited_reg[adj_rd_data])
                begin
                    visited_next[adj_rd_data] = 1'b1;
                    strobe_next = 1'b1;
                    status_next = ST_VISIT;
                    vid_next    = pend_reg;
                    last_next   = 1'b0;
                    pend_next   = adj_rd_data;
                    stk_wr_en   = 1'b1;
                    depth_next  = depth_reg + VidW'(1);
                    cur_u_next  = adj_rd_data;
                    cur_i_next  = '0;
                    vt_rd_addr  = adj_rd_data;
                    state_next  = S_WALK_LEN;
                end
                else
                begin
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_POP:
            begin
                cur_u_next = stk_rd_data[StackW-1:LenW];
                cur_i_next = stk_rd_data[LenW-1:0];
                vt_rd_addr = stk_rd_data[StackW-1:LenW];
                state_next = S_WALK_LEN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            visited_reg <= '0;
            depth_reg   <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            visited_reg <= visited_next;
            depth_reg   <= depth_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        len_a_reg   <= len_a_next;
        cur_u_reg   <= cur_u_next;
        cur_i_reg   <= cur_i_next;
        cur_len_reg <= cur_len_next;
        pend_reg    <= pend_next;
        status_reg  <= status_next;
        vid_reg     <= vid_next;
        last_reg    <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign vertex_id     = vid_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

>>> tb/sv/graph_dfs_visit_order_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module graph_dfs_visit_order_core_test
    import gdv_pkg::*;
;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      op;
    logic [VidW-1:0] vertex_a;
    logic [VidW-1:0] vertex_b;
    logic            result_strobe;
    logic [1:0]      status;
    logic [VidW-1:0] vertex_id;
    logic            last;

    typedef struct packed {
        logic [1:0]      status;
        logic [VidW-1:0] vertex_id;
        logic            last;
    } visit_beat_t;

    // Mirror of the graph held by the block.
    bit     present_mark [MaxVertices];
    bit     visited_mark [MaxVertices];
    bit     edge_mark    [MaxVertices][MaxVertices];
    int     neighbor_list[MaxVertices][$];

    visit_beat_t expected_beats[$];
    int          error_count;

    graph_dfs_visit_order_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .result_strobe (result_strobe),
        .status        (status),
        .vertex_id     (vertex_id),
        .last          (last)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void push_beat(status_t st, int vid, bit fin);
        visit_beat_t b;
        b.status    = st;
        b.vertex_id = vid[VidW-1:0];
        b.last      = fin;
        expected_beats = {expected_beats, b};
    endfunction

    // Work out the beats that one command produces and advance the mirror.
    function automatic void predict_command(op_t cmd, int a, int b);
        int vstack[$];
        int istack[$];
        int u;
        int i;
        int w;
        case (cmd)
            OP_VERTEX:
            begin
                present_mark[a] = 1'b1;
            end
            OP_EDGE:
            begin
                if (!present_mark[a] || !present_mark[b])
                    push_beat(ST_MISSING, 0, 1'b1);
                else if (edge_mark[a][b])
                    push_beat(ST_DUP, 0, 1'b1);
                else
                begin
                    edge_mark[a][b] = 1'b1;
                    edge_mark[b][a] = 1'b1;
                    neighbor_list[a] = {neighbor_list[a], b};
                    neighbor_list[b] = {neighbor_list[b], a};
                end
            end
            OP_WALK:
            begin
                if (!present_mark[a])
                    push_beat(ST_MISSING, 0, 1'b1);
                else if (!visited_mark[a])
                begin
                    visited_mark[a] = 1'b1;
                    push_beat(ST_VISIT, a, 1'b0);
                    vstack = {vstack, a};
                    istack = {istack, 0};
                    while (vstack.size() > 0)
                    begin
                        u = vstack[$];
                        i = istack[$];
                        if (i >= neighbor_list[u].size())
                        begin
                            void'(vstack.pop_back());
                            void'(istack.pop_back());
                        end
                        else
                        begin
                            istack[istack.size()-1] = i + 1;
                            w = neighbor_list[u][i];
                            if (!visited_mark[w])
                            begin
                                visited_mark[w] = 1'b1;
                                push_beat(ST_VISIT, w, 1'b0);
                                vstack = {vstack, w};
                                istack = {istack, 0};
                            end
                        end
                    end
                    expected_beats[expected_beats.size()-1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Commands go out in bursts: hold a random gap before each burst.
    int burst_left;

    task automatic send_command(op_t cmd, int a, int b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        op       <= cmd;
        vertex_a <= a[VidW-1:0];
        vertex_b <= b[VidW-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Beat taken at this edge; start stays up for the next beat of the burst.
        predict_command(cmd, a, b);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        visit_beat_t e;
        if (rst_n && result_strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat status=%0d vertex_id=%0d last=%0d",
                       status, vertex_id, last);
                error_count++;
            end
            else
            begin
                e = expected_beats.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    error_count++;
                end
                if (vertex_id !== e.vertex_id)
                begin
                    $error("vertex_id expected %0d actual %0d", e.vertex_id, vertex_id);
                    error_count++;
                end
                if (last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, last);
                    error_count++;
                end
            end
        end
    end

    // Directed: extremes, every op, every special case.
    task automatic test_directed();
        send_command(OP_EDGE, 0, 63);      // missing endpoints
        send_command(OP_WALK, 63, 0);      // walk from a missing vertex
        send_command(OP_NONE, 21, 42);     // unused op is ignored
        send_command(OP_VERTEX, 0, 63);
        send_command(OP_VERTEX, 63, 0);
        send_command(OP_VERTEX, 63, 21);   // already present
        send_command(OP_EDGE, 0, 42);      // one endpoint missing
        send_command(OP_VERTEX, 42, 21);
        send_command(OP_VERTEX, 21, 42);
        send_command(OP_EDGE, 0, 63);
        send_command(OP_EDGE, 63, 0);      // duplicate, order swapped
        send_command(OP_EDGE, 21, 21);     // self-loop
        send_command(OP_EDGE, 21, 21);     // duplicate self-loop
        send_command(OP_EDGE, 63, 42);
        send_command(OP_EDGE, 0, 21);
        send_command(OP_WALK, 0, 63);
        send_command(OP_WALK, 42, 0);      // already visited
        send_command(OP_VERTEX, 1, 0);
        send_command(OP_WALK, 1, 0);       // isolated vertex
        wait_drained();
    endtask

    // Random: a mix of vertex, edge, walk and unused commands on random vertices.
    task automatic test_random();
        int n;
        int a;
        int b;
        int r;
        for (n = 0; n < 135; n++)
        begin
            r = $urandom_range(0, 99);
            a = $urandom_range(0, 63);
            b = ($urandom_range(0, 3) == 0) ? a ^ 6'h3f : $urandom_range(0, 63);
            if (r < 25)
                send_command(OP_VERTEX, a, b);
            else if (r < 70)
                send_command(OP_EDGE, a, b);
            else if (r < 93)
                send_command(OP_WALK, a, b);
            else
                send_command(OP_NONE, a, b);
            if (n == 60)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        start       = 1'b0;
        op          = OP_VERTEX;
        vertex_a    = '0;
        vertex_b    = '0;
        rst_n       = 1'b0;
        error_count = 0;
        burst_left  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("graph_dfs_visit_order_core_test passed");
        else
            $display("graph_dfs_visit_order_core_test failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("graph_dfs_visit_order_core_test failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> graph_dfs_visit_order_core.f
hw/rtl/gdv_pkg.sv
hw/rtl/gdv_ram.sv
hw/rtl/gdv_vertex_table.sv
hw/rtl/graph_dfs_visit_order_core.sv
tb/sv/graph_dfs_visit_order_core_test.sv
